FILE: sv/gyro_quaternion_integrator_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gyro quaternion integrator
// Implication checks on clk, disabled while rst is high; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef GYRO_QUATERNION_INTEGRATOR_UNIT_ASSERT_SVH
`define GYRO_QUATERNION_INTEGRATOR_UNIT_ASSERT_SVH
`ifndef SYNTH
`define GQI_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gqi check failed");
`define GQI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gqi check failed");
`else
`define GQI_ASSERT_SAME(label, ante, cons)
`define GQI_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: sv/gqi_pkg.sv
// ----------------------------------------------------------------------------
// gqi_pkg
// Shared constants, types and helper functions of the quaternion integrator.
// ----------------------------------------------------------------------------
package gqi_pkg;

  localparam logic signed [23:0] Q_ONE = 24'sd4194304;
  localparam logic signed [23:0] Q_MAX = 24'sd8388607;
  localparam logic signed [23:0] Q_MIN = -24'sd8388608;
  localparam logic [48:0] NORM_SQ_THRESHOLD = 49'd175921;

  typedef enum logic {RD_SQRT, RD_DIV} rd_mode_t;

  typedef struct packed {
    logic     start;
    rd_mode_t mode;
  } rd_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rd_stat_t;

  typedef struct packed {
    logic [1:0] q_idx;
    logic [1:0] h_idx;
    logic       neg;
  } term_sel_t;

  // Saturate to the Q2.22 range.
  function automatic logic signed [23:0] sat_q(input logic signed [49:0] v);
    logic signed [23:0] r;
    if (v > 50'(Q_MAX)) r = Q_MAX;
    else if (v < 50'(Q_MIN)) r = Q_MIN;
    else r = v[23:0];
    return r;
  endfunction

  // Quaternion product terms: component, term -> (q index, rate index, sign).
  function automatic term_sel_t term_sel(input logic [1:0] comp, input logic [1:0] t);
    term_sel_t s;
    unique case ({comp, t})
      4'h0:    s = '{2'd1, 2'd0, 1'b1};
      4'h1:    s = '{2'd2, 2'd1, 1'b1};
      4'h2:    s = '{2'd3, 2'd2, 1'b1};
      4'h4:    s = '{2'd0, 2'd0, 1'b0};
      4'h5:    s = '{2'd2, 2'd2, 1'b0};
      4'h6:    s = '{2'd3, 2'd1, 1'b1};
      4'h8:    s = '{2'd0, 2'd1, 1'b0};
      4'h9:    s = '{2'd1, 2'd2, 1'b1};
      4'hA:    s = '{2'd3, 2'd0, 1'b0};
      4'hC:    s = '{2'd0, 2'd2, 1'b0};
      4'hD:    s = '{2'd1, 2'd1, 1'b0};
      4'hE:    s = '{2'd2, 2'd0, 1'b1};
      default: s = '{2'd0, 2'd0, 1'b0};
    endcase
    return s;
  endfunction

endpackage

FILE: sv/gqi_mac.sv
// ----------------------------------------------------------------------------
// gqi_mac
// Shared signed 25x25 multiplier with a registered product.
// ----------------------------------------------------------------------------
module gqi_mac (
  input  logic               clk,
  input  logic signed [24:0] a,
  input  logic signed [24:0] b,
  output logic signed [49:0] prod
);
  always_ff @(posedge clk) begin
    prod <= a * b;
  end
endmodule

FILE: sv/gqi_rootdiv.sv
// ----------------------------------------------------------------------------
// gqi_rootdiv
// Bit-serial square root and rounded divide on one shared subtractor.
// ----------------------------------------------------------------------------
module gqi_rootdiv (
  input  logic             clk,
  input  logic             rst,
  input  gqi_pkg::rd_cmd_t cmd,
  input  logic [48:0]      radicand,
  input  logic [23:0]      mag,
  output logic [23:0]      quo,
  output logic             ovf,
  output gqi_pkg::rd_stat_t stat
);
  import gqi_pkg::*;

  rd_mode_t    mode;
  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  logic [24:0] root;
  logic [27:0] rem;
  logic [49:0] rad;
  logic [23:0] num_lo;
  logic [27:0] wrem;
  logic [27:0] trial;
  logic [27:0] diff;
  logic        ge;
  logic [45:0] num;
  logic        ovf_c;

  // Shared trial subtract: root digit pair or next dividend bit.
  always_comb begin
    if (mode == RD_SQRT) begin
      wrem  = {rem[25:0], rad[49:48]};
      trial = {1'b0, root, 2'b01};
    end else begin
      wrem  = {rem[26:0], num_lo[23]};
      trial = {3'b000, root};
    end
    ge   = (wrem >= trial);
    diff = wrem - trial;
    num   = {mag, 22'd0} + {22'd0, root[24:1]};
    ovf_c = ({3'b000, num} >= {root, 24'd0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        mode <= cmd.mode;
        busy <= 1'b1;
        if (cmd.mode == RD_SQRT) begin
          rad  <= {1'b0, radicand};
          rem  <= '0;
          root <= '0;
          cnt  <= 5'd24;
        end else begin
          rem    <= {6'd0, num[45:24]};
          num_lo <= num[23:0];
          quo    <= '0;
          ovf    <= ovf_c;
          cnt    <= 5'd23;
        end
      end else if (busy) begin
        rem <= ge ? diff : wrem;
        if (mode == RD_SQRT) begin
          root <= {root[23:0], ge};
          rad  <= {rad[47:0], 2'b00};
        end else begin
          quo    <= {quo[22:0], ge};
          num_lo <= {num_lo[22:0], 1'b0};
        end
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

  assign stat = '{busy: busy, done: done};
endmodule

FILE: sv/gyro_quaternion_integrator_unit.sv
// ----------------------------------------------------------------------------
// gyro_quaternion_integrator_unit
// First-order quaternion integration of gyro rates with renormalisation.
// ----------------------------------------------------------------------------
// Use: present rate_x/y/z (rad/s, 2^-12) and time_step (s, 2^-16) with
// in_valid; a beat is taken when in_valid is high and in_stall low. in_stall
// stays high while an update is being worked, so one beat is in flight.
// Each beat yields one result beat on quat_w/x/y/z (Q2.22) with out_valid;
// the receiver holds it off with out_stall. The result sits in an output
// register, so a new input beat is taken while the old result waits.
// The shared 25x25 multiplier does the first part (24 products, one rounding
// step per component, one norm check); when the sum is renormalised, the
// bit-serial root/divide unit does the rest (the root, then 4 divides).
// Throughput: the next beat is taken the cycle after the result is loaded.
// Reset restores the identity attitude (w = 1.0) and empties the output.
// A stalled receiver holds the finished result in the sequencer until the
// output register drains; no beat is dropped.
// ----------------------------------------------------------------------------
module gyro_quaternion_integrator_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [19:0] rate_x,
  input  logic signed [19:0] rate_y,
  input  logic signed [19:0] rate_z,
  input  logic        [15:0] time_step,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [23:0] quat_w,
  output logic signed [23:0] quat_x,
  output logic signed [23:0] quat_y,
  output logic signed [23:0] quat_z
);
  import gqi_pkg::*;

`include "gyro_quaternion_integrator_unit_assert.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ACC, S_ROUND, S_SQ, S_SQACC, S_CHECK,
    S_SQRT, S_DIVGO, S_DIVWAIT, S_OUT
  } state_t;

  state_t             state;
  logic [1:0]         comp;
  logic [2:0]         op;
  logic signed [19:0] rate [3];
  logic [15:0]        dt;
  logic signed [23:0] attitude [4];
  logic signed [23:0] res [4];
  logic signed [45:0] acc_s;
  logic signed [63:0] acc_d;
  logic [48:0]        acc_sq;

  logic signed [24:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [49:0] prod;
  term_sel_t          tsel;
  logic signed [19:0] rate_sel;
  logic signed [63:0] rnd;
  logic signed [49:0] sum_c;
  logic signed [63:0] prod_ext;
  rd_cmd_t            rd_cmd;
  rd_stat_t           rd_stat;
  logic [23:0]        rd_quo;
  logic               rd_ovf;
  logic [23:0]        mag;
  logic [23:0]        q_div;
  logic signed [25:0] q_signed;
  logic               out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Operand selection for the shared multiplier.
  always_comb begin
    tsel = term_sel(comp, op[1:0]);
    unique case (tsel.h_idx)
      2'd0:    rate_sel = rate[0];
      2'd1:    rate_sel = rate[1];
      default: rate_sel = rate[2];
    endcase
    mul_a = '0;
    mul_b = '0;
    if (state == S_MUL) begin
      if (op < 3'd3) begin
        mul_a = 25'(attitude[tsel.q_idx]);
        mul_b = 25'(rate_sel);
      end else if (op == 3'd3) begin
        mul_a = {2'b00, acc_s[22:0]};
        mul_b = {9'd0, dt};
      end else begin
        mul_a = {{2{acc_s[45]}}, acc_s[45:23]};
        mul_b = {9'd0, dt};
      end
    end else if (state == S_SQ) begin
      mul_a = 25'(res[comp]);
      mul_b = 25'(res[comp]);
    end
  end

  gqi_mac u_mac (.clk(clk), .a(mul_a), .b(mul_b), .prod(prod));

  // Round the derivative term to Q2.22 (half towards +inf) and add.
  always_comb begin
    prod_ext = 64'(prod);
    rnd      = acc_d + (64'sd1 <<< 28);
    sum_c    = 50'(attitude[comp]) + 50'(rnd >>> 29);
    mag      = res[comp][23] ? 24'(-25'(res[comp])) : res[comp];
    q_div    = rd_ovf ? '1 : rd_quo;
    q_signed = res[comp][23] ? -26'({2'b00, q_div}) : 26'({2'b00, q_div});
    rd_cmd.start = ((state == S_CHECK) && (acc_sq > NORM_SQ_THRESHOLD)) ||
                   (state == S_DIVGO);
    rd_cmd.mode  = (state == S_DIVGO) ? RD_DIV : RD_SQRT;
  end

  gqi_rootdiv u_rootdiv (
    .clk(clk), .rst(rst), .cmd(rd_cmd), .radicand(acc_sq), .mag(mag),
    .quo(rd_quo), .ovf(rd_ovf), .stat(rd_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      attitude[0] <= Q_ONE;
      attitude[1] <= '0;
      attitude[2] <= '0;
      attitude[3] <= '0;
    end else begin
      // drop the result once it is taken, unless a new one replaces it
      if (out_valid && !out_stall && (state != S_OUT)) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            rate[0] <= rate_x;
            rate[1] <= rate_y;
            rate[2] <= rate_z;
            dt      <= time_step;
            comp    <= 2'd0;
            op      <= 3'd0;
            acc_s   <= '0;
            state   <= S_MUL;
          end
        end
        S_MUL: state <= S_ACC;
        S_ACC: begin
          if (op < 3'd3) begin
            acc_s <= tsel.neg ? acc_s - prod[45:0] : acc_s + prod[45:0];
          end else if (op == 3'd3) begin
            acc_d <= prod_ext;
          end else begin
            acc_d <= acc_d + (prod_ext <<< 23);
          end
          if (op == 3'd4) begin
            state <= S_ROUND;
          end else begin
            op    <= op + 3'd1;
            state <= S_MUL;
          end
        end
        S_ROUND: begin
          res[comp] <= sat_q(sum_c);
          op        <= 3'd0;
          acc_s     <= '0;
          if (comp == 2'd3) begin
            comp   <= 2'd0;
            acc_sq <= '0;
            state  <= S_SQ;
          end else begin
            comp  <= comp + 2'd1;
            state <= S_MUL;
          end
        end
        S_SQ: state <= S_SQACC;
        S_SQACC: begin
          acc_sq <= acc_sq + prod[48:0];
          if (comp == 2'd3) begin
            state <= S_CHECK;
          end else begin
            comp  <= comp + 2'd1;
            state <= S_SQ;
          end
        end
        S_CHECK: state <= (acc_sq > NORM_SQ_THRESHOLD) ? S_SQRT : S_OUT;
        S_SQRT: begin
          if (rd_stat.done) begin
            comp  <= 2'd0;
            state <= S_DIVGO;
          end
        end
        S_DIVGO: state <= S_DIVWAIT;
        S_DIVWAIT: begin
          if (rd_stat.done) begin
            res[comp] <= sat_q(50'(q_signed));
            if (comp == 2'd3) begin
              state <= S_OUT;
            end else begin
              comp  <= comp + 2'd1;
              state <= S_DIVGO;
            end
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (out_free) begin
            quat_w    <= res[0];
            quat_x    <= res[1];
            quat_y    <= res[2];
            quat_z    <= res[3];
            attitude  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `GQI_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, state == S_MUL)
  `GQI_ASSERT_NEXT(a_result_loaded, state == S_OUT && out_free, out_valid)
  `GQI_ASSERT_SAME(a_rootdiv_owned, rd_stat.busy || rd_stat.done,
                   state == S_SQRT || state == S_DIVWAIT)
endmodule
